// File: design/grr_pkg.sv
// shared types, constants and pixel functions for the glyph row rasterizer
`default_nettype none

package grr_pkg;

    typedef logic [2:0] t_cfg_index;

    localparam t_cfg_index CFG_FRAME_BASE     = 3'd0;
    localparam t_cfg_index CFG_SCREEN_WIDTH   = 3'd1;
    localparam t_cfg_index CFG_BITS_PER_PIXEL = 3'd2;
    localparam t_cfg_index CFG_GLYPH_HEIGHT   = 3'd3;
    localparam t_cfg_index CFG_GLYPH_WIDTH    = 3'd4;

    localparam int CFG_DATA_W = 32;

    localparam logic [31:0] RST_FRAME_BASE     = 32'd0;
    localparam logic [10:0] RST_SCREEN_WIDTH   = 11'd640;
    localparam logic [3:0]  RST_BITS_PER_PIXEL = 4'd8;
    localparam logic [4:0]  RST_GLYPH_HEIGHT   = 5'd16;
    localparam logic [3:0]  RST_GLYPH_WIDTH    = 4'd8;

    localparam logic REQ_DRAW = 1'b0;
    localparam logic REQ_LOAD = 1'b1;

    localparam logic [3:0] BPP_8 = 4'd8;
    localparam logic [3:0] BPP_4 = 4'd4;

    localparam logic [3:0] COUNT_8BPP = 4'd8;
    localparam logic [3:0] COUNT_4BPP = 4'd4;

    localparam logic [1:0] COLOR8_TOP = 2'b11;
    localparam logic [1:0] LEVEL_BRIGHT = 2'd3;
    localparam logic [1:0] LEVEL_NORMAL = 2'd2;
    localparam logic [1:0] LEVEL_OFF    = 2'd0;

    // irgb to 0xc0 | rrggbb
    function automatic logic [7:0] map_color8(input logic [3:0] c);
        logic [1:0] lvl;
        logic [1:0] rr;
        logic [1:0] gg;
        logic [1:0] bb;
        lvl = c[3] ? LEVEL_BRIGHT : LEVEL_NORMAL;
        rr  = c[2] ? lvl : LEVEL_OFF;
        gg  = c[1] ? lvl : LEVEL_OFF;
        bb  = c[0] ? lvl : LEVEL_OFF;
        return {COLOR8_TOP, rr, gg, bb};
    endfunction

    // one glyph line into packed pixels (bytes at 8 bpp, nibbles at 4 bpp), bit 0 is the leftmost pixel
    function automatic logic [63:0] pack_line(input logic [7:0] g,
                                              input logic [7:0] cf,
                                              input logic [7:0] cb,
                                              input logic       half);
        logic [63:0] d;
        d = '0;
        for (int i = 0; i < 8; i++) begin
            if (half) begin
                d[4*i +: 4] = g[i] ? cf[3:0] : cb[3:0];
            end else begin
                d[8*i +: 8] = g[i] ? cf : cb;
            end
        end
        return d;
    endfunction

endpackage

`default_nettype wire

// File: design/grr_store.sv
// glyph row memory, one write port and one registered read port
`default_nettype none

module grr_store #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [7:0]    i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [7:0]    o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: design/grr_mul.sv
// shared registered multiplier for the address and index setup
`default_nettype none

module grr_mul #(
    parameter int AW = 18,
    parameter int BW = 7
) (
    input  wire logic             i_clk,
    input  wire logic [AW-1:0]    i_a,
    input  wire logic [BW-1:0]    i_b,
    output logic      [AW+BW-1:0] o_q
);

    logic [AW+BW-1:0] r_q;

    always_ff @(posedge i_clk) begin
        r_q <= (AW+BW)'(i_a) * (AW+BW)'(i_b);
    end

    assign o_q = r_q;

endmodule

`default_nettype wire

// File: design/glyph_row_rasterizer.sv
// top level: glyph row rasterizer with sequencer, shared multiplier and glyph store
//
// input channel (i_valid / o_stall) takes load and draw beats. a load beat writes
// one glyph row byte into the store in the cycle it is accepted and gives no output.
// a draw beat makes one output beat (o_valid / i_stall) per glyph line.
// o_stall is high from a draw beat's acceptance until its last line is loaded
// into the output register, so one draw is worked at a time.
// a draw first runs five setup steps through the shared multiplier (pitch*row,
// code*height, col*width, row offset), then an index reduce state that repeats
// once per needed wrap of the glyph index (none when depth covers 256*max height),
// a read state, then one line per cycle out of the store read port while the
// receiver does not stall.
// a draw at an unsupported pixel depth or zero height is taken and dropped.
// when the receiver stalls, the output register holds its beat and the
// sequencer waits with the next glyph byte parked in the store read register.
// reset (synchronous, active low) returns the sequencer to idle, empties the
// output register and loads the default configuration; the store is not cleared.
// configuration writes are taken every cycle and must only happen while idle.
`default_nettype none

module glyph_row_rasterizer #(
    parameter int GLYPH_STORE_DEPTH = 4096,
    parameter int MAX_GLYPH_HEIGHT  = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_wr_en,
    input  wire grr_pkg::t_cfg_index           i_cfg_index,
    input  wire logic [grr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic                          i_req_type,
    input  wire logic [7:0]                    i_char_code,
    input  wire logic [7:0]                    i_cell_col,
    input  wire logic [6:0]                    i_cell_row,
    input  wire logic [3:0]                    i_fg_color,
    input  wire logic [3:0]                    i_bg_color,
    input  wire logic [11:0]                   i_glyph_index,
    input  wire logic [7:0]                    i_glyph_bits,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [31:0]                        o_write_addr,
    output logic [63:0]                        o_write_data,
    output logic [3:0]                         o_byte_count,
    output logic                               o_last
);

    localparam int AW  = $clog2(GLYPH_STORE_DEPTH);
    localparam int HW  = $clog2(MAX_GLYPH_HEIGHT + 1);
    localparam int IW  = $clog2(256 * MAX_GLYPH_HEIGHT);
    localparam int RW  = (IW > AW) ? IW : AW;
    localparam int LW  = 11 + HW;
    localparam int MAW = 18;
    localparam int MBW = (HW > 7) ? HW : 7;
    localparam int MQW = MAW + MBW;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_PR    = 4'd1;
    localparam logic [3:0] S_CH    = 4'd2;
    localparam logic [3:0] S_CW    = 4'd3;
    localparam logic [3:0] S_TH    = 4'd4;
    localparam logic [3:0] S_ADD   = 4'd5;
    localparam logic [3:0] S_RED   = 4'd6;
    localparam logic [3:0] S_PRIME = 4'd7;
    localparam logic [3:0] S_DRAW  = 4'd8;

    // configuration
    logic [31:0] r_frame_base;
    logic [10:0] r_screen_width;
    logic [3:0]  r_bpp;
    logic [4:0]  r_glyph_height;
    logic [3:0]  r_glyph_width;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_base   <= grr_pkg::RST_FRAME_BASE;
            r_screen_width <= grr_pkg::RST_SCREEN_WIDTH;
            r_bpp          <= grr_pkg::RST_BITS_PER_PIXEL;
            r_glyph_height <= grr_pkg::RST_GLYPH_HEIGHT;
            r_glyph_width  <= grr_pkg::RST_GLYPH_WIDTH;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                grr_pkg::CFG_FRAME_BASE:     r_frame_base   <= i_cfg_data[31:0];
                grr_pkg::CFG_SCREEN_WIDTH:   r_screen_width <= i_cfg_data[10:0];
                grr_pkg::CFG_BITS_PER_PIXEL: r_bpp          <= i_cfg_data[3:0];
                grr_pkg::CFG_GLYPH_HEIGHT:   r_glyph_height <= i_cfg_data[4:0];
                grr_pkg::CFG_GLYPH_WIDTH:    r_glyph_width  <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // sequencer state and draw context
    logic [3:0]    r_state;
    logic [7:0]    r_code;
    logic [7:0]    r_col;
    logic [6:0]    r_row;
    logic [7:0]    r_cf;
    logic [7:0]    r_cb;
    logic          r_half;
    logic [HW-1:0] r_h;
    logic [17:0]   r_t1;
    logic [RW-1:0] r_idx;
    logic [31:0]   r_addr0;
    logic [LW-1:0] r_loff;
    logic [HW-1:0] r_line;

    logic          in_accept;
    logic          is_load;
    logic          draw_ok;
    logic [HW-1:0] h_eff;
    logic          out_free;
    logic          line_last;
    logic          rd_en;
    logic [RW-1:0] idx_next;

    logic [MAW-1:0] mul_a;
    logic [MBW-1:0] mul_b;
    logic [MQW-1:0] mul_q;
    logic [7:0]     glyph_q;

    assign o_stall   = (r_state != S_IDLE);
    assign in_accept = i_valid && !o_stall;
    assign is_load   = (i_req_type == grr_pkg::REQ_LOAD);
    assign draw_ok   = ((r_bpp == grr_pkg::BPP_8) || (r_bpp == grr_pkg::BPP_4))
                       && (r_glyph_height != 5'd0);
    assign h_eff     = (32'(r_glyph_height) > 32'(MAX_GLYPH_HEIGHT))
                       ? HW'(MAX_GLYPH_HEIGHT) : HW'(r_glyph_height);
    assign out_free  = !o_valid || !i_stall;
    assign line_last = (r_line == r_h - HW'(1));
    assign idx_next  = (r_idx == RW'(GLYPH_STORE_DEPTH - 1)) ? '0 : r_idx + RW'(1);
    assign rd_en     = (r_state == S_PRIME)
                       || ((r_state == S_DRAW) && out_free && !line_last);

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_PR: begin
                mul_a = MAW'(r_screen_width);
                mul_b = MBW'(r_row);
            end
            S_CH: begin
                mul_a = MAW'(r_code);
                mul_b = MBW'(r_h);
            end
            S_CW: begin
                mul_a = MAW'(r_col);
                mul_b = MBW'(r_glyph_width);
            end
            S_TH: begin
                mul_a = r_t1;
                mul_b = MBW'(r_h);
            end
            default: ;
        endcase
    end

    grr_mul #(
        .AW (MAW),
        .BW (MBW)
    ) u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_q   (mul_q)
    );

    grr_store #(
        .DEPTH (GLYPH_STORE_DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (in_accept && is_load
                  && (32'(i_glyph_index) < 32'(GLYPH_STORE_DEPTH))),
        .i_waddr (AW'(i_glyph_index)),
        .i_wdata (i_glyph_bits),
        .i_re    (rd_en),
        .i_raddr (AW'(r_idx)),
        .o_rdata (glyph_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_accept && !is_load && draw_ok) begin
                        r_state <= S_PR;
                    end
                end
                S_PR:    r_state <= S_CH;
                S_CH:    r_state <= S_CW;
                S_CW:    r_state <= S_TH;
                S_TH:    r_state <= S_ADD;
                S_ADD:   r_state <= S_RED;
                S_RED: begin
                    if (32'(r_idx) < 32'(GLYPH_STORE_DEPTH)) begin
                        r_state <= S_PRIME;
                    end
                end
                S_PRIME: r_state <= S_DRAW;
                S_DRAW: begin
                    if (out_free && line_last) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_code <= i_char_code;
                r_col  <= i_cell_col;
                r_row  <= i_cell_row;
                r_h    <= h_eff;
                r_half <= (r_bpp == grr_pkg::BPP_4);
                if (r_bpp == grr_pkg::BPP_4) begin
                    r_cf <= {4'd0, i_fg_color};
                    r_cb <= {4'd0, i_bg_color};
                end else begin
                    r_cf <= grr_pkg::map_color8(i_fg_color);
                    r_cb <= grr_pkg::map_color8(i_bg_color);
                end
            end
            S_CH: r_t1 <= mul_q[17:0];
            S_CW: r_idx <= RW'(mul_q);
            S_TH: r_addr0 <= r_frame_base + 32'(mul_q >> r_half);
            S_ADD: begin
                r_addr0 <= r_addr0 + 32'(mul_q >> r_half);
                r_loff  <= '0;
                r_line  <= '0;
            end
            S_RED: begin
                if (32'(r_idx) >= 32'(GLYPH_STORE_DEPTH)) begin
                    r_idx <= r_idx - RW'(GLYPH_STORE_DEPTH);
                end
            end
            S_PRIME: r_idx <= idx_next;
            S_DRAW: begin
                if (out_free && !line_last) begin
                    r_idx  <= idx_next;
                    r_line <= r_line + HW'(1);
                    r_loff <= r_loff + LW'(r_screen_width);
                end
            end
            default: ;
        endcase
    end

    // output register
    logic        r_out_valid;
    logic [31:0] r_out_addr;
    logic [63:0] r_out_data;
    logic [3:0]  r_out_count;
    logic        r_out_last;
    logic        out_load;

    assign out_load = (r_state == S_DRAW) && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_addr  <= r_addr0 + 32'(r_loff >> r_half);
            r_out_data  <= grr_pkg::pack_line(glyph_q, r_cf, r_cb, r_half);
            r_out_count <= r_half ? grr_pkg::COUNT_4BPP : grr_pkg::COUNT_8BPP;
            r_out_last  <= line_last;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_write_addr = r_out_addr;
    assign o_write_data = r_out_data;
    assign o_byte_count = r_out_count;
    assign o_last       = r_out_last;

endmodule

`default_nettype wire
